// ===== hw/rtl/skf_pkg.sv =====
`default_nettype none
package skf_pkg;
    localparam logic [1:0] OP_SCALAR = 2'd0;
    localparam logic [1:0] OP_AXIS   = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;
    localparam logic [1:0] REG_Q  = 2'd0;
    localparam logic [1:0] REG_R  = 2'd1;
    localparam logic [1:0] REG_EN = 2'd2;
endpackage
`default_nettype wire

// ===== hw/rtl/skf_update.sv =====
`default_nettype none
// One Kalman update: bit-serial restoring divide for the gain, then
// shift-add multiplies one bit per cycle for the estimate step and covariance.
module skf_update #(
    parameter int FRAC_BITS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  wire signed [31:0] meas,
    input  wire signed [31:0] est,
    input  wire        [31:0] cov,
    input  wire        [30:0] q,
    input  wire        [30:0] r,
    output logic              done,
    output logic signed [31:0] est_new,
    output logic       [31:0] cov_new,
    output logic [FRAC_BITS:0] gain
);
    localparam int NW = 32 + FRAC_BITS;   // dividend width
    localparam int DW = 34;
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_MUL = 3'd2, S_FIN = 3'd3;

    logic [2:0] st_reg, st_next;
    logic [5:0] cnt_reg;
    logic [31:0] pp_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic signed [33:0] diff_reg;
    logic signed [33+FRAC_BITS+2:0] acc_e_reg;   // K*diff
    logic [32+FRAC_BITS+1:0] acc_p_reg;           // (1-K)*pp
    logic [FRAC_BITS:0] km_reg;                   // K shifted out lsb first
    logic [FRAC_BITS+1:0] omk_reg;                // 1-K shifted out
    logic signed [31:0] est_reg;

    logic [32:0] pp_sum;
    logic [DW-1:0] rem_sh, rem_sub;
    logic signed [33+FRAC_BITS+2:0] eprod;

    always_comb
    begin
        pp_sum  = {1'b0, cov} + {2'b0, q};
        rem_sh  = {rem_reg[DW-2:0], quo_reg[NW-1]};
        rem_sub = rem_sh - den_reg;
        eprod   = acc_e_reg + $signed({{(FRAC_BITS+2){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (start) st_next = S_DIV;
            S_DIV:  if (cnt_reg == 6'(NW-1)) st_next = S_MUL;
            S_MUL:  if (cnt_reg == 6'(FRAC_BITS+1)) st_next = S_FIN;
            S_FIN:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg != st_next) cnt_reg <= '0;
            else cnt_reg <= cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                pp_reg   <= pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
                den_reg  <= (pp_sum[32] ? 34'h0_FFFF_FFFF : {1'b0, pp_sum}) + {3'b0, r};
                quo_reg  <= {(pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0]),
                             {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                diff_reg <= 34'(meas) - 34'(est);
                est_reg  <= est;
            end
            S_DIV:
            begin
                if (!rem_sub[DW-1])
                begin
                    rem_reg <= rem_sub;
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
                acc_e_reg <= '0;
                acc_p_reg <= '0;
            end
            S_MUL:
            begin
                if (cnt_reg == 6'd0)
                begin
                    km_reg  <= quo_reg[FRAC_BITS:0];
                    omk_reg <= (FRAC_BITS+2)'(1 << FRAC_BITS) - {1'b0, quo_reg[FRAC_BITS:0]};
                    gain    <= quo_reg[FRAC_BITS:0];
                end
                else
                begin
                    if (km_reg[0])
                        acc_e_reg <= acc_e_reg + ($signed(diff_reg) <<< (cnt_reg - 6'd1));
                    if (omk_reg[0])
                        acc_p_reg <= acc_p_reg + ({{(FRAC_BITS+2){1'b0}}, pp_reg}
                                                  << (cnt_reg - 6'd1));
                    km_reg  <= km_reg >> 1;
                    omk_reg <= omk_reg >> 1;
                end
            end
            S_FIN: ;
            default: ;
        endcase
    end

    // Accumulators are final during S_FIN, so results are valid with done.
    assign est_new = est_reg + 32'(eprod >>> FRAC_BITS);
    assign cov_new = acc_p_reg[FRAC_BITS+31:FRAC_BITS];
    assign done = (st_reg == S_FIN);
endmodule
`default_nettype wire

// ===== hw/rtl/scalar_kalman_filter.sv =====
`default_nettype none
// Channel  | Dir | Payload
// s_axis   | in  | tdata: opcode[1:0], measure_x, measure_y, measure_z (+6 pad)
// m_axis   | out | tdata: estimate_x, estimate_y, estimate_z, scalar_gain (+7 pad)
// cfg      | in  | cfg_we, cfg_index, cfg_data (31 bit)
// One update pass (start, divide, multiply, finish) runs in the shared
// bit-serial unit. A filtered scalar item takes one pass, an axis item
// three (one per axis); pass-through, reset and unused-opcode items skip
// the unit and go from accept through S_OUT to the output register.
// Async reset loads the noise defaults and clears estimates and gain.
// One item in flight; the result sits in the output register and s_tready
// stays low until it is taken.
module scalar_kalman_filter #(
    parameter int FRAC_BITS = 16,
    parameter int AXES = 3
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [103:0] s_tdata,   // opcode, measure_x, measure_y, measure_z
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [119:0] m_tdata,   // estimate_x, estimate_y, estimate_z, scalar_gain
    input  wire          cfg_we,
    input  wire  [1:0]   cfg_index,
    input  wire  [30:0]  cfg_data
);
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
    localparam int NMIN_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam logic [30:0] NMIN = (NMIN_RAW == 0) ? 31'd1 : 31'(NMIN_RAW);
    localparam int AX = (AXES < 3) ? AXES : 3;
    localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_WAIT = 2'd2, S_OUT = 2'd3;

    logic [30:0] q_reg, r_reg;
    logic en_reg;
    logic [1:0] st_reg;
    logic [1:0] op_reg;
    logic [1:0] ax_reg;
    logic signed [31:0] meas_reg [3];
    logic signed [31:0] sest_reg;
    logic [31:0] scov_reg;
    logic [FRAC_BITS:0] sgain_reg;
    logic signed [31:0] aest_reg [AXES];
    logic [31:0] acov_reg [AXES];
    logic signed [31:0] ox_reg, oy_reg, oz_reg;

    logic u_start, u_done;
    logic signed [31:0] u_meas, u_est, u_est_new;
    logic [31:0] u_cov, u_cov_new;
    logic [FRAC_BITS:0] u_gain;
    logic [30:0] cfg_clamped;

    assign cfg_clamped = (cfg_data < NMIN) ? NMIN : cfg_data;
    assign s_tready = (st_reg == S_IDLE) && !m_tvalid;
    assign u_start  = (st_reg == S_RUN);
    assign u_meas = meas_reg[ax_reg];
    assign u_est  = (op_reg == skf_pkg::OP_SCALAR) ? sest_reg : aest_reg[ax_reg];
    assign u_cov  = (op_reg == skf_pkg::OP_SCALAR) ? scov_reg : acov_reg[ax_reg];

    skf_update #(.FRAC_BITS(FRAC_BITS)) u_upd (
        .clk(clk), .rst_n(rst_n), .start(u_start), .meas(u_meas), .est(u_est),
        .cov(u_cov), .q(q_reg), .r(r_reg), .done(u_done), .est_new(u_est_new),
        .cov_new(u_cov_new), .gain(u_gain)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= 31'(((1 << FRAC_BITS) + 50) / 100);
            r_reg <= 31'(((1 << FRAC_BITS) + 5) / 10);
            en_reg <= 1'b0;
            st_reg <= S_IDLE;
            m_tvalid <= 1'b0;
            sest_reg <= '0;
            scov_reg <= ONE;
            sgain_reg <= '0;
            ax_reg <= '0;
            op_reg <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                aest_reg[i] <= '0;
                acov_reg[i] <= ONE;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    skf_pkg::REG_Q:  q_reg <= cfg_clamped;
                    skf_pkg::REG_R:  r_reg <= cfg_clamped;
                    skf_pkg::REG_EN: en_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                    if (s_tvalid && s_tready)
                    begin
                        op_reg <= s_tdata[1:0];
                        meas_reg[0] <= s_tdata[33:2];
                        meas_reg[1] <= s_tdata[65:34];
                        meas_reg[2] <= s_tdata[97:66];
                        ax_reg <= '0;
                        if (en_reg && (s_tdata[1:0] == skf_pkg::OP_SCALAR ||
                                       (s_tdata[1:0] == skf_pkg::OP_AXIS && AX > 0)))
                            st_reg <= S_RUN;
                        else
                            st_reg <= S_OUT;
                    end
                S_RUN: st_reg <= S_WAIT;
                S_WAIT:
                    if (u_done)
                    begin
                        if (op_reg == skf_pkg::OP_SCALAR)
                        begin
                            sest_reg <= u_est_new;
                            scov_reg <= u_cov_new;
                            sgain_reg <= u_gain;
                            st_reg <= S_OUT;
                        end
                        else
                        begin
                            aest_reg[ax_reg] <= u_est_new;
                            acov_reg[ax_reg] <= u_cov_new;
                            if (ax_reg == 2'(AX - 1)) st_reg <= S_OUT;
                            else
                            begin
                                ax_reg <= ax_reg + 2'd1;
                                st_reg <= S_RUN;
                            end
                        end
                    end
                S_OUT:
                begin
                    st_reg <= S_IDLE;
                    m_tvalid <= 1'b1;
                    unique case (op_reg)
                        skf_pkg::OP_SCALAR:
                        begin
                            if (!en_reg) sest_reg <= meas_reg[0];
                            ox_reg <= en_reg ? sest_reg : meas_reg[0];
                            oy_reg <= '0;
                            oz_reg <= '0;
                        end
                        skf_pkg::OP_AXIS:
                        begin
                            for (int i = 0; i < AX; i++)
                                if (!en_reg) aest_reg[i] <= meas_reg[i];
                            ox_reg <= (AX > 0) ? (en_reg ? aest_reg[0] : meas_reg[0]) : '0;
                            oy_reg <= (AX > 1) ? (en_reg ? aest_reg[AX > 1 ? 1 : 0]
                                                         : meas_reg[1]) : '0;
                            oz_reg <= (AX > 2) ? (en_reg ? aest_reg[AX > 2 ? 2 : 0]
                                                         : meas_reg[2]) : '0;
                        end
                        default:
                        begin
                            if (op_reg == skf_pkg::OP_RESET)
                            begin
                                scov_reg <= ONE;
                                sgain_reg <= '0;
                                for (int i = 0; i < AXES; i++) acov_reg[i] <= ONE;
                            end
                            ox_reg <= sest_reg;
                            oy_reg <= '0;
                            oz_reg <= '0;
                        end
                    endcase
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Gain reported after the item; reset op clears it.
    logic [16:0] gain_out;
    assign gain_out = 17'(sgain_reg);
    logic gain_zero_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) gain_zero_reg <= 1'b0;
        else if (st_reg == S_OUT) gain_zero_reg <= (op_reg == skf_pkg::OP_RESET);
    end
    assign m_tdata = {7'b0, (gain_zero_reg ? 17'd0 : gain_out), oz_reg, oy_reg, ox_reg};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !s_tready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_start_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> (st_reg == S_WAIT)) else $error("stray done");
endmodule
`default_nettype wire

// ===== bench/tb_scalar_kalman_filter.sv =====
`default_nettype none

// Expected-result store for the filter: tracks Q, R, enable and the channel
// states, predicts one result per accepted item and checks results in order.
class kalman_scoreboard;
    logic [30:0]  q_noise;
    logic [30:0]  r_noise;
    bit           enabled;
    longint       est_s;
    longint       cov_s;
    longint       gain_s;
    longint       est_a[3];
    longint       cov_a[3];
    logic [119:0] pending[$];
    int           errors;
    int           n_results;

    function void reset_state();
        q_noise = 31'd655;
        r_noise = 31'd6554;
        enabled = 0;
        est_s   = 0;
        errors  = 0;
        n_results = 0;
        for (int i = 0; i < 3; i++)
            est_a[i] = 0;
        clear_cov();
    endfunction

    function void clear_cov();
        cov_s  = 65536;
        gain_s = 0;
        for (int i = 0; i < 3; i++)
            cov_a[i] = 65536;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] val);
        logic [30:0] v;
        v = (val < 31'd7) ? 31'd7 : val;
        if (idx == skf_pkg::REG_Q)
            q_noise = v;
        else if (idx == skf_pkg::REG_R)
            r_noise = v;
        else if (idx == skf_pkg::REG_EN)
            enabled = val[0];
    endfunction

    // One Kalman step; 64-bit products stay exact (K < 2^16, diff < 2^33).
    function longint filter_step(longint meas, inout longint est, inout longint cov);
        longint pp;
        longint k;
        longint prod;
        longint sh;
        pp = cov + longint'(q_noise);
        if (pp > 64'hFFFF_FFFF)
            pp = 64'hFFFF_FFFF;
        k = (pp << 16) / (pp + longint'(r_noise));
        prod = k * (meas - est) + 32768;
        sh = prod >>> 16;           // arithmetic shift is floor
        est = est + sh;
        cov = (((65536 - k) * pp) >> 16) & 64'hFFFF_FFFF;
        return k;
    endfunction

    function void note_item(logic [103:0] d);
        logic [1:0] op;
        longint     m[3];
        logic [31:0] ex, ey, ez;
        op = d[1:0];
        m[0] = longint'($signed(d[33:2]));
        m[1] = longint'($signed(d[65:34]));
        m[2] = longint'($signed(d[97:66]));
        ey = 0;
        ez = 0;
        if (op == skf_pkg::OP_SCALAR) begin
            if (enabled)
                gain_s = filter_step(m[0], est_s, cov_s);
            else
                est_s = m[0];
            ex = est_s[31:0];
        end else if (op == skf_pkg::OP_AXIS) begin
            for (int i = 0; i < 3; i++) begin
                if (enabled)
                    void'(filter_step(m[i], est_a[i], cov_a[i]));
                else
                    est_a[i] = m[i];
            end
            ex = est_a[0][31:0];
            ey = est_a[1][31:0];
            ez = est_a[2][31:0];
        end else begin
            if (op == skf_pkg::OP_RESET)
                clear_cov();
            ex = est_s[31:0];
        end
        pending.push_back({7'd0, gain_s[16:0], ez, ey, ex});
    endfunction

    function void check_result(logic [119:0] got);
        logic [119:0] exp_d;
        n_results++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp_d = pending.pop_front();
        if (got[31:0] !== exp_d[31:0]) begin
            $display("%0t: estimate_x expected %h actual %h", $time, exp_d[31:0], got[31:0]);
            errors++;
        end
        if (got[63:32] !== exp_d[63:32]) begin
            $display("%0t: estimate_y expected %h actual %h", $time, exp_d[63:32],
                     got[63:32]);
            errors++;
        end
        if (got[95:64] !== exp_d[95:64]) begin
            $display("%0t: estimate_z expected %h actual %h", $time, exp_d[95:64],
                     got[95:64]);
            errors++;
        end
        if (got[112:96] !== exp_d[112:96]) begin
            $display("%0t: scalar_gain expected %h actual %h", $time, exp_d[112:96],
                     got[112:96]);
            errors++;
        end
    endfunction
endclass

module tb_scalar_kalman_filter;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;     // opcode[1:0], measure_x, measure_y, measure_z, pad
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [119:0] m_tdata;          // estimate_x, estimate_y, estimate_z, scalar_gain, pad
    logic         cfg_we = 0;
    logic [1:0]   cfg_index = '0;
    logic [30:0]  cfg_data = '0;

    kalman_scoreboard sb;
    int  n_items = 0;
    int  op_seen[4];
    bit  sending_done = 0;

    scalar_kalman_filter uut (.*);

    always #10 clk = ~clk;

    // Result side: random stall per result, sampled at the rising edge.
    initial begin : sink
        int stall;
        sb = new();
        sb.reset_state();
        forever begin
            @(negedge clk);
            stall = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0)
                stall = 0;              // stretches without stalls
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_result(m_tdata);
        end
    end

    // Leaves s_tvalid high on return; drain() or a gap before the next item takes it down.
    task automatic send_item(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {6'd0, z, y, x, op};
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_item({6'd0, z, y, x, op});
        op_seen[op]++;
        n_items++;
        @(negedge clk);
    endtask

    // Wait for all results, plus slack for a block still busy.
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [30:0] val);
        @(negedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] rnd_meas();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [1:0] rnd_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9) return skf_pkg::OP_SCALAR;
        if (r < 17) return skf_pkg::OP_AXIS;
        if (r < 19) return skf_pkg::OP_RESET;
        return skf_pkg::OP_NONE;        // unused opcode: no state change
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            send_item(rnd_op(), rnd_meas(), rnd_meas(), rnd_meas());
            if (i == count / 2) drain();    // hold sender until all results are back
        end
        drain();
    endtask

    initial begin : stim
        repeat (3) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Pass-through at reset defaults, extremes and every opcode.
        send_item(skf_pkg::OP_SCALAR, 32'h7FFF_FFFF, 0, 0);
        send_item(skf_pkg::OP_AXIS, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(skf_pkg::OP_RESET, 32'h1234_5678, 1, 2);
        send_item(skf_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Filtering with default noise, then extreme swings.
        write_cfg(skf_pkg::REG_EN, 31'd1);
        send_item(skf_pkg::OP_SCALAR, 32'h0001_0000, 0, 0);
        send_item(skf_pkg::OP_SCALAR, 32'h8000_0000, 0, 0);
        send_item(skf_pkg::OP_SCALAR, 32'h7FFF_FFFF, 0, 0);
        send_item(skf_pkg::OP_AXIS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_item(skf_pkg::OP_AXIS, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(skf_pkg::OP_NONE, 0, 0, 0);
        send_item(skf_pkg::OP_RESET, 0, 0, 0);
        send_item(skf_pkg::OP_SCALAR, 32'h0000_8000, 0, 0);
        drain();

        // Smallest noise (clamped up), then largest: saturating prediction.
        write_cfg(skf_pkg::REG_Q, 31'd0);
        write_cfg(skf_pkg::REG_R, 31'd3);
        send_item(skf_pkg::OP_SCALAR, 32'h0100_0000, 0, 0);
        send_item(skf_pkg::OP_AXIS, 32'hFF00_0000, 32'h0010_0000, 32'h8000_0000);
        drain();
        write_cfg(skf_pkg::REG_Q, 31'h7FFF_FFFF);
        write_cfg(skf_pkg::REG_R, 31'h7FFF_FFFF);
        for (int i = 0; i < 5; i++)
            send_item(skf_pkg::OP_SCALAR, rnd_meas(), 0, 0);
        send_item(skf_pkg::OP_AXIS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        drain();

        // Random phases with varying noise and enable.
        for (int ph = 0; ph < 8; ph++) begin
            write_cfg(skf_pkg::REG_Q, (ph % 3 == 0) ? 31'($urandom_range(0, 15))
                                                    : 31'($urandom()));
            write_cfg(skf_pkg::REG_R, (ph % 2 == 0) ? 31'($urandom_range(0, 70000))
                                                    : 31'($urandom()));
            write_cfg(skf_pkg::REG_EN, (ph == 3) ? 31'h7FFF_FFFE : 31'h7FFF_FFFF);
            random_phase(48);
        end
        drain();
        sending_done = 1;
    end

    initial begin : finish_ctl
        wait (sending_done);
        $display("Sent %0d items (ops 0/1/2/3: %0d/%0d/%0d/%0d), checked %0d results.",
                 n_items, op_seen[0], op_seen[1], op_seen[2], op_seen[3], sb.n_results);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("scalar_kalman_filter: match");
        else
            $display("scalar_kalman_filter: mismatch");
        $finish;
    end

    // Covers 404 items plus their stalls and drains.
    initial begin : watchdog
        #40ms;
        $display("Timeout with %0d results outstanding.", sb.pending.size());
        $display("scalar_kalman_filter: mismatch");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/skf_pkg.sv
hw/rtl/skf_update.sv
hw/rtl/scalar_kalman_filter.sv
bench/tb_scalar_kalman_filter.sv
